// File: hw/rtl/alm_pkg.sv
`timescale 1ns / 1ps

package alm_pkg;

    localparam int DEPTH   = 128;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int PTR_W   = 8;
    localparam int POS_W   = 8;
    localparam int SLOT_W  = 7;
    localparam int VAL_W   = 32;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(DEPTH);

    typedef enum logic [1:0] {
        OP_INS_POS   = 2'd0,
        OP_DEL_POS   = 2'd1,
        OP_INS_AFTER = 2'd2,
        OP_DEL_AFTER = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_NO_SUCC = 2'd3
    } status_t;

endpackage

// File: hw/rtl/alm_cmd_if.sv
`timescale 1ns / 1ps

interface alm_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       opcode;
    logic [alm_pkg::POS_W-1:0]        position;
    logic [alm_pkg::SLOT_W-1:0]       slot;
    logic signed [alm_pkg::VAL_W-1:0] value;

    modport source (output valid, output opcode, output position, output slot,
                    output value, input ready);
    modport sink   (input valid, input opcode, input position, input slot,
                    input value, output ready);
endinterface

// File: hw/rtl/alm_rsp_if.sv
`timescale 1ns / 1ps

interface alm_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [alm_pkg::SLOT_W-1:0]       node_slot;
    logic signed [alm_pkg::VAL_W-1:0] removed_value;
    logic [alm_pkg::PTR_W-1:0]        list_count;
    logic [alm_pkg::PTR_W-1:0]        head_slot;

    modport source (output valid, output status, output node_slot,
                    output removed_value, output list_count, output head_slot,
                    input ready);
    modport sink   (input valid, input status, input node_slot,
                    input removed_value, input list_count, input head_slot,
                    output ready);
endinterface

// File: hw/rtl/array_linked_list_manager_unit.sv
`timescale 1ns / 1ps

// Singly linked list of signed 32-bit values in a 128-node store, with unused
// nodes chained on a free list. Each command on cmd gives exactly one response
// on rsp; a failed command (bad position or slot, store full, no successor)
// leaves the list untouched. Commands are handled one at a time. A position
// command at position p of 2 or more first follows p - 1 links from the head,
// one per cycle, through the single read port of the link memory. The next
// command can be taken in the cycle after its response is loaded. A response
// waiting in the output register does not block the next command transfer,
// only the loading of its response. No clearing pass is needed after reset.
module array_linked_list_manager_unit (
    input  logic      clk,
    input  logic      rst_n,
    alm_cmd_if.sink   cmd,
    alm_rsp_if.source rsp
);

    localparam int IW = alm_pkg::IDX_W;
    localparam int PW = alm_pkg::PTR_W;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_START = 12'b0000_0000_0010,
        S_WALK  = 12'b0000_0000_0100,
        S_INS_A = 12'b0000_0000_1000,
        S_INS_B = 12'b0000_0001_0000,
        S_INS_C = 12'b0000_0010_0000,
        S_INS_D = 12'b0000_0100_0000,
        S_DEL_A = 12'b0000_1000_0000,
        S_DEL_B = 12'b0001_0000_0000,
        S_DEL_C = 12'b0010_0000_0000,
        S_DEL_D = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    alm_pkg::opcode_t                 op_reg, op_next;
    logic [alm_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [alm_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [alm_pkg::VAL_W-1:0]        val_reg, val_next;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] free_reg, free_next;
    logic [PW-1:0] count_reg, count_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] n_reg, n_next;
    logic [PW-1:0] free_nx_reg, free_nx_next;
    logic [alm_pkg::POS_W-1:0] cnt_reg, cnt_next;
    logic          head_mode_reg, head_mode_next;

    alm_pkg::status_t           res_status_reg, res_status_next;
    logic [alm_pkg::SLOT_W-1:0] res_node_reg, res_node_next;
    logic [alm_pkg::VAL_W-1:0]  res_removed_reg, res_removed_next;

    logic                       out_valid_reg, out_valid_next;
    alm_pkg::status_t           out_status_reg, out_status_next;
    logic [alm_pkg::SLOT_W-1:0] out_node_reg, out_node_next;
    logic [alm_pkg::VAL_W-1:0]  out_removed_reg, out_removed_next;
    logic [PW-1:0]              out_count_reg, out_count_next;
    logic [PW-1:0]              out_head_reg, out_head_next;

    // link and data memories, valid bits stand in for the link reset pattern
    logic [PW-1:0]            link_mem [alm_pkg::DEPTH];
    logic [alm_pkg::VAL_W-1:0] data_mem [alm_pkg::DEPTH];
    logic [alm_pkg::DEPTH-1:0] lvalid_reg;
    logic [alm_pkg::DEPTH-1:0] member_reg;
    logic                      slot_mb_reg;

    logic [PW-1:0] rd_addr;
    logic [IW-1:0] rd_idx_reg;
    logic          rd_null_reg;
    logic          rd_def_reg;
    logic [PW-1:0] link_q_reg;
    logic [alm_pkg::VAL_W-1:0] data_q_reg;
    logic [PW-1:0] raw_q;
    logic [PW-1:0] follow_q;

    logic          lk_we;
    logic [IW-1:0] lk_waddr;
    logic [PW-1:0] lk_wdata;
    logic          dt_we;
    logic          mb_set;
    logic          mb_clr;

    logic cmd_xfer;
    logic slot_bad;
    logic load_out;

    assign cmd_xfer = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    // membership of the slot is sampled at the command transfer
    assign slot_bad = (PW'(slot_reg) >= alm_pkg::NULL_PTR) || !slot_mb_reg;

    // successor of the node read in the previous cycle, null-saturated
    assign raw_q = rd_def_reg ? (PW'(rd_idx_reg) + PW'(1)) : link_q_reg;
    assign follow_q = (rd_null_reg || raw_q >= alm_pkg::NULL_PTR)
                    ? alm_pkg::NULL_PTR : raw_q;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        pos_next         = pos_reg;
        slot_next        = slot_reg;
        val_next         = val_reg;
        head_next        = head_reg;
        free_next        = free_reg;
        count_next       = count_reg;
        prev_next        = prev_reg;
        n_next           = n_reg;
        free_nx_next     = free_nx_reg;
        cnt_next         = cnt_reg;
        head_mode_next   = head_mode_reg;
        res_status_next  = res_status_reg;
        res_node_next    = res_node_reg;
        res_removed_next = res_removed_reg;
        rd_addr          = alm_pkg::NULL_PTR;
        lk_we            = 1'b0;
        lk_waddr         = n_reg[IW-1:0];
        lk_wdata         = alm_pkg::NULL_PTR;
        dt_we            = 1'b0;
        mb_set           = 1'b0;
        mb_clr           = 1'b0;
        load_out         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    op_next    = alm_pkg::opcode_t'(cmd.opcode);
                    pos_next   = cmd.position;
                    slot_next  = cmd.slot;
                    val_next   = cmd.value;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                res_status_next  = alm_pkg::ST_OK;
                res_node_next    = '0;
                res_removed_next = '0;
                head_mode_next   = 1'b0;
                prev_next        = alm_pkg::NULL_PTR;
                cnt_next         = pos_reg - alm_pkg::POS_W'(1);
                case (op_reg)
                    alm_pkg::OP_INS_POS:
                    begin
                        if (pos_reg > count_reg)
                        begin
                            res_status_next = alm_pkg::ST_BAD_POS;
                            state_next      = S_DONE;
                        end
                        else if (free_reg == alm_pkg::NULL_PTR)
                        begin
                            res_status_next = alm_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else if (pos_reg == '0)
                        begin
                            head_mode_next = 1'b1;
                            state_next     = S_INS_A;
                        end
                        else if (pos_reg == alm_pkg::POS_W'(1))
                        begin
                            prev_next  = head_reg;
                            state_next = S_INS_A;
                        end
                        else
                        begin
                            rd_addr    = head_reg;
                            state_next = S_WALK;
                        end
                    end
                    alm_pkg::OP_DEL_POS:
                    begin
                        if (pos_reg >= count_reg || head_reg == alm_pkg::NULL_PTR)
                        begin
                            res_status_next = alm_pkg::ST_BAD_POS;
                            state_next      = S_DONE;
                        end
                        else if (pos_reg == '0)
                        begin
                            head_mode_next = 1'b1;
                            n_next         = head_reg;
                            rd_addr        = head_reg;
                            state_next     = S_DEL_C;
                        end
                        else if (pos_reg == alm_pkg::POS_W'(1))
                        begin
                            prev_next  = head_reg;
                            state_next = S_DEL_A;
                        end
                        else
                        begin
                            rd_addr    = head_reg;
                            state_next = S_WALK;
                        end
                    end
                    alm_pkg::OP_INS_AFTER:
                    begin
                        if (slot_bad)
                        begin
                            res_status_next = alm_pkg::ST_BAD_POS;
                            state_next      = S_DONE;
                        end
                        else if (free_reg == alm_pkg::NULL_PTR)
                        begin
                            res_status_next = alm_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            prev_next  = PW'(slot_reg);
                            state_next = S_INS_A;
                        end
                    end
                    default:
                    begin
                        if (slot_bad)
                        begin
                            res_status_next = alm_pkg::ST_BAD_POS;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            prev_next  = PW'(slot_reg);
                            state_next = S_DEL_A;
                        end
                    end
                endcase
            end
            S_WALK:
            begin
                // one link per cycle, read data feeds the next address
                if (cnt_reg == alm_pkg::POS_W'(1))
                begin
                    prev_next  = follow_q;
                    state_next = (op_reg == alm_pkg::OP_INS_POS) ? S_INS_A : S_DEL_A;
                end
                else
                begin
                    rd_addr  = follow_q;
                    cnt_next = cnt_reg - alm_pkg::POS_W'(1);
                end
            end
            S_INS_A:
            begin
                n_next     = free_reg;
                rd_addr    = free_reg;
                state_next = S_INS_B;
            end
            S_INS_B:
            begin
                free_nx_next = follow_q;
                rd_addr      = prev_reg;
                state_next   = S_INS_C;
            end
            S_INS_C:
            begin
                lk_we    = 1'b1;
                lk_waddr = n_reg[IW-1:0];
                if (head_mode_reg)
                    lk_wdata = head_reg;
                else if (prev_reg < alm_pkg::NULL_PTR)
                    lk_wdata = follow_q;
                else
                    lk_wdata = alm_pkg::NULL_PTR;
                dt_we      = 1'b1;
                state_next = S_INS_D;
            end
            S_INS_D:
            begin
                if (!head_mode_reg && prev_reg < alm_pkg::NULL_PTR)
                begin
                    lk_we    = 1'b1;
                    lk_waddr = prev_reg[IW-1:0];
                    lk_wdata = n_reg;
                end
                else
                begin
                    head_next = n_reg;
                end
                free_next     = free_nx_reg;
                count_next    = count_reg + PW'(1);
                mb_set        = 1'b1;
                res_node_next = n_reg[alm_pkg::SLOT_W-1:0];
                state_next    = S_DONE;
            end
            S_DEL_A:
            begin
                rd_addr    = prev_reg;
                state_next = S_DEL_B;
            end
            S_DEL_B:
            begin
                n_next = follow_q;
                if (follow_q == alm_pkg::NULL_PTR)
                begin
                    res_status_next = alm_pkg::ST_NO_SUCC;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_addr    = follow_q;
                    state_next = S_DEL_C;
                end
            end
            S_DEL_C:
            begin
                // unlink the node; data read of n lands next cycle
                if (head_mode_reg)
                begin
                    head_next = follow_q;
                end
                else
                begin
                    lk_we    = 1'b1;
                    lk_waddr = prev_reg[IW-1:0];
                    lk_wdata = follow_q;
                end
                state_next = S_DEL_D;
            end
            S_DEL_D:
            begin
                lk_we            = 1'b1;
                lk_waddr         = n_reg[IW-1:0];
                lk_wdata         = free_reg;
                free_next        = n_reg;
                count_next       = count_reg - PW'(1);
                mb_clr           = 1'b1;
                res_removed_next = data_q_reg;
                res_node_next    = n_reg[alm_pkg::SLOT_W-1:0];
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_node_next    = out_node_reg;
        out_removed_next = out_removed_reg;
        out_count_next   = out_count_reg;
        out_head_next    = out_head_reg;
        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;
        if (load_out)
        begin
            out_valid_next   = 1'b1;
            out_status_next  = res_status_reg;
            out_node_next    = res_node_reg;
            out_removed_next = res_removed_reg;
            out_count_next   = count_reg;
            out_head_next    = head_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.node_slot     = out_node_reg;
    assign rsp.removed_value = out_removed_reg;
    assign rsp.list_count    = out_count_reg;
    assign rsp.head_slot     = out_head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= alm_pkg::NULL_PTR;
            free_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            lvalid_reg    <= '0;
            member_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (lk_we)
                lvalid_reg[lk_waddr] <= 1'b1;
            if (mb_set)
                member_reg[n_reg[IW-1:0]] <= 1'b1;
            if (mb_clr)
                member_reg[n_reg[IW-1:0]] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        pos_reg         <= pos_next;
        slot_reg        <= slot_next;
        val_reg         <= val_next;
        prev_reg        <= prev_next;
        n_reg           <= n_next;
        free_nx_reg     <= free_nx_next;
        cnt_reg         <= cnt_next;
        head_mode_reg   <= head_mode_next;
        res_status_reg  <= res_status_next;
        res_node_reg    <= res_node_next;
        res_removed_reg <= res_removed_next;
        out_status_reg  <= out_status_next;
        out_node_reg    <= out_node_next;
        out_removed_reg <= out_removed_next;
        out_count_reg   <= out_count_next;
        out_head_reg    <= out_head_next;
        slot_mb_reg     <= member_reg[cmd.slot[IW-1:0]];
    end

    // link memory: one read, one write port
    always_ff @(posedge clk)
    begin
        if (lk_we)
            link_mem[lk_waddr] <= lk_wdata;
        link_q_reg  <= link_mem[rd_addr[IW-1:0]];
        rd_idx_reg  <= rd_addr[IW-1:0];
        rd_null_reg <= (rd_addr >= alm_pkg::NULL_PTR);
        rd_def_reg  <= !lvalid_reg[rd_addr[IW-1:0]];
    end

    // data memory
    always_ff @(posedge clk)
    begin
        if (dt_we)
            data_mem[n_reg[IW-1:0]] <= val_reg;
        data_q_reg <= data_mem[n_reg[IW-1:0]];
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= PW'(alm_pkg::DEPTH))
        else $error("node count above store depth");

    a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE)
        |-> ((head_reg == alm_pkg::NULL_PTR) == (count_reg == '0)))
        else $error("list head and node count disagree");

    a_free_full: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg == alm_pkg::NULL_PTR) == (count_reg == PW'(alm_pkg::DEPTH)))
        else $error("free list and node count disagree");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_D) |=> (count_reg == $past(count_reg) + PW'(1)))
        else $error("insert did not grow the list");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_DONE))
        else $error("response raised outside completion");
`endif

endmodule
